// ===== src/gppp_pkg.sv =====
// ----------------------------------------------------------------------------
// gppp_pkg
// Register map, register widths and reset values of the ground plane
// pixel projection core.
// ----------------------------------------------------------------------------
`default_nettype none

package gppp_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_HEIGHT   = 3'd4
    } cfg_reg_t;

    localparam int FOCAL_BITS  = 24;
    localparam int CENTER_BITS = 16;
    localparam int HEIGHT_BITS = 16;
    // height * focal_y
    localparam int HF_BITS     = HEIGHT_BITS + FOCAL_BITS;
    // split point of the wide product du*h*focal_y
    localparam int SPLIT_BITS  = 18;

    localparam logic [FOCAL_BITS-1:0]  FOCAL_X_RESET = 24'd128000;
    localparam logic [FOCAL_BITS-1:0]  FOCAL_Y_RESET = 24'd128000;
    localparam logic [CENTER_BITS-1:0] CENTER_X_RESET = 16'd5120;
    localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET = 16'd3840;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET   = 16'd500;

endpackage

`default_nettype wire

// ===== src/gppp_div_cell.sv =====
// ----------------------------------------------------------------------------
// gppp_div_cell
// One restoring division step: settle one quotient bit and pass the
// partial remainder on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gppp_div_cell #(
    parameter int NW    = 60,
    parameter int DW    = 44,
    parameter int QW    = 24,
    parameter int TW    = 1,
    parameter int SHIFT = 0
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] rem_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [QW-1:0] quo_in,
    input  wire logic [TW-1:0] tag_in,
    output logic      [NW-1:0] rem_out,
    output logic      [DW-1:0] den_out,
    output logic      [QW-1:0] quo_out,
    output logic      [TW-1:0] tag_out
);

    logic [NW-1:0] den_ext;
    logic          hit;
    logic [NW-1:0] rem_next;
    logic [QW-1:0] quo_next;
    logic [NW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg;
    logic [TW-1:0] tag_reg;

    assign den_ext = {{(NW-DW){1'b0}}, den_in};

    // a hit guarantees that den << SHIFT fits below the remainder
    always_comb begin
        hit      = (rem_in >> SHIFT) >= den_ext;
        rem_next = hit ? (rem_in - (den_ext << SHIFT)) : rem_in;
        quo_next = quo_in | (QW'(hit) << SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
            tag_reg <= tag_in;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
    assign tag_out = tag_reg;

endmodule

`default_nettype wire

// ===== src/gppp_divider.sv =====
// ----------------------------------------------------------------------------
// gppp_divider
// Row of division cells, most significant quotient bit first. The top
// quotient bit flags a quotient too large for QW-1 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gppp_divider #(
    parameter int NW = 60,
    parameter int DW = 44,
    parameter int QW = 24,
    parameter int TW = 1
) (
    input  wire logic          aclk,
    input  wire logic [QW-1:0] en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [TW-1:0] tag_in,
    output logic      [QW-1:0] quo,
    output logic      [TW-1:0] tag_out
);

    logic [NW-1:0] rem_w [0:QW];
    logic [DW-1:0] den_w [0:QW];
    logic [QW-1:0] quo_w [0:QW];
    logic [TW-1:0] tag_w [0:QW];

    assign rem_w[0] = num;
    assign den_w[0] = den;
    assign quo_w[0] = '0;
    assign tag_w[0] = tag_in;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        gppp_div_cell #(
            .NW(NW), .DW(DW), .QW(QW), .TW(TW), .SHIFT(QW-1-k)
        ) u_cell (
            .aclk   (aclk),
            .en     (en[k]),
            .rem_in (rem_w[k]),
            .den_in (den_w[k]),
            .quo_in (quo_w[k]),
            .tag_in (tag_w[k]),
            .rem_out(rem_w[k+1]),
            .den_out(den_w[k+1]),
            .quo_out(quo_w[k+1]),
            .tag_out(tag_w[k+1])
        );
    end

    assign quo     = quo_w[QW];
    assign tag_out = tag_w[QW];

endmodule

`default_nettype wire

// ===== src/ground_plane_pixel_projection_core.sv =====
// ----------------------------------------------------------------------------
// ground_plane_pixel_projection_core
// Projects a lane pixel onto the flat ground plane of a level camera.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one pixel (column, row) per transfer.
//   Result channel m_*: forward and left distance in mm, saturated.
//   Config channel cfg_*: always ready; write only while the core is idle.
//   Index 0..4 = focal_x, focal_y, center_x, center_y, height;
//   other indexes are ignored.
// Throughput: one pixel per cycle while the receiver takes results, set by the
//   row of division cells, one quotient bit per cell, each cell its own pipeline stage.
// Pipeline from input transfer to m_valid: one stage
//   of products, two of the wide numerator product and sum, then OUT_BITS
//   division cells, then the output register.
// Pixels at or above the horizon, or with zero height or zero focal_y,
//   produce no result and leave a bubble.
// Reset clears every stage valid and restores the register defaults.
// Receiver stall: each stage holds only when it is full and the next
//   one holds, so inputs keep flowing until the pipeline fills up.
// ----------------------------------------------------------------------------
`default_nettype none

module ground_plane_pixel_projection_core #(
    parameter int PIXEL_BITS = 12,
    parameter int OUT_BITS   = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIXEL_BITS-1:0] s_pixel_column,
    input  wire logic [PIXEL_BITS-1:0] s_pixel_row,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [OUT_BITS-2:0]   m_forward_mm,
    output logic signed [OUT_BITS-1:0] m_left_mm,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [gppp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [gppp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int FB  = gppp_pkg::FOCAL_BITS;
    localparam int CB  = gppp_pkg::CENTER_BITS;
    localparam int HB  = gppp_pkg::HEIGHT_BITS;
    localparam int HFB = gppp_pkg::HF_BITS;
    localparam int SB  = gppp_pkg::SPLIT_BITS;
    localparam int UW  = PIXEL_BITS + 4;             // pixel in 1/16 px
    localparam int DUW = (UW > CB) ? UW : CB;        // |du| and compares
    localparam int DHW = DUW + HB;                   // |du| * height
    localparam int HIW = DHW - SB;
    localparam int NW  = DUW + HFB;                  // left numerator
    localparam int LDW = FB + UW;                    // focal_x * dv
    localparam int FDW = UW + 4;                     // 16 * dv
    localparam int QW  = OUT_BITS;                   // quotient + overflow
    localparam int NS  = 3 + QW;                     // pipeline stages
    localparam logic [OUT_BITS-2:0] LIMIT = '1;

    // ---------------- configuration registers ----------------
    logic [FB-1:0] focal_x_reg, focal_y_reg;
    logic [CB-1:0] center_x_reg, center_y_reg;
    logic [HB-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= gppp_pkg::FOCAL_X_RESET;
            focal_y_reg  <= gppp_pkg::FOCAL_Y_RESET;
            center_x_reg <= gppp_pkg::CENTER_X_RESET;
            center_y_reg <= gppp_pkg::CENTER_Y_RESET;
            height_reg   <= gppp_pkg::HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                gppp_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg_data[FB-1:0];
                gppp_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg_data[FB-1:0];
                gppp_pkg::REG_CENTER_X: center_x_reg <= cfg_data[CB-1:0];
                gppp_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[CB-1:0];
                gppp_pkg::REG_HEIGHT:   height_reg   <= cfg_data[HB-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------- stage control ----------------
    // en[i]: stage i may load. A stage loads when empty or when it moves on.
    logic [NS-1:0] v_reg;
    logic [NS:0]   en;
    logic          m_valid_reg;

    assign en[NS] = !m_valid_reg || m_ready;
    for (genvar i = 0; i < NS; i++) begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end
    assign s_ready = en[0];

    // ---------------- stage 0: geometry and first products ----------------
    logic [DUW-1:0] ucol, urow, cx, cy, du_mag, dv_full;
    logic [UW-1:0]  dv;
    logic           keep, du_neg;

    always_comb begin
        ucol    = DUW'({s_pixel_column, 4'b0000});
        urow    = DUW'({s_pixel_row, 4'b0000});
        cx      = DUW'(center_x_reg);
        cy      = DUW'(center_y_reg);
        keep    = (urow > cy) && (height_reg != '0) && (focal_y_reg != '0);
        dv_full = urow - cy;
        dv      = dv_full[UW-1:0];
        du_neg  = ucol < cx;
        du_mag  = du_neg ? (cx - ucol) : (ucol - cx);
    end

    logic [DHW-1:0] a_duh_reg;
    logic [HFB-1:0] a_hf_reg;
    logic [LDW-1:0] a_ldiv_reg;
    logic [FDW-1:0] a_fdiv_reg;
    logic [FB-1:0]  a_fy_reg;
    logic           a_neg_reg, a_zero_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_duh_reg  <= DHW'(du_mag * height_reg);
            a_hf_reg   <= HFB'(height_reg * focal_y_reg);
            a_ldiv_reg <= LDW'(focal_x_reg * dv);
            a_fdiv_reg <= {dv, 4'b0000};
            a_fy_reg   <= focal_y_reg;
            a_neg_reg  <= du_neg;
            a_zero_reg <= (du_mag == '0);
        end
    end

    // ---------------- stage 1: split product |du|*h*focal_y ----------------
    logic [SB+FB-1:0]  b_lo_reg;
    logic [HIW+FB-1:0] b_hi_reg;
    logic [HFB-1:0]    b_hf_reg;
    logic [LDW-1:0]    b_ldiv_reg;
    logic [FDW-1:0]    b_fdiv_reg;
    logic              b_neg_reg, b_zero_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            b_lo_reg   <= (SB+FB)'(a_duh_reg[SB-1:0] * a_fy_reg);
            b_hi_reg   <= (HIW+FB)'(a_duh_reg[DHW-1:SB] * a_fy_reg);
            b_hf_reg   <= a_hf_reg;
            b_ldiv_reg <= a_ldiv_reg;
            b_fdiv_reg <= a_fdiv_reg;
            b_neg_reg  <= a_neg_reg;
            b_zero_reg <= a_zero_reg;
        end
    end

    // ---------------- stage 2: sum the numerator ----------------
    logic [NW-1:0]  c_num_reg;
    logic [HFB-1:0] c_hf_reg;
    logic [LDW-1:0] c_ldiv_reg;
    logic [FDW-1:0] c_fdiv_reg;
    logic           c_neg_reg, c_zero_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            c_num_reg  <= NW'(b_lo_reg) + (NW'(b_hi_reg) << SB);
            c_hf_reg   <= b_hf_reg;
            c_ldiv_reg <= b_ldiv_reg;
            c_fdiv_reg <= b_fdiv_reg;
            c_neg_reg  <= b_neg_reg;
            c_zero_reg <= b_zero_reg;
        end
    end

    // ---------------- division rows ----------------
    logic [QW-1:0] fwd_quo, left_quo;
    logic          d_neg, d_zero;

    gppp_divider #(.NW(HFB), .DW(FDW), .QW(QW), .TW(1)) u_fwd_div (
        .aclk   (aclk),
        .en     (en[NS-1:3]),
        .num    (c_hf_reg),
        .den    (c_fdiv_reg),
        .tag_in (c_neg_reg),
        .quo    (fwd_quo),
        .tag_out(d_neg)
    );

    gppp_divider #(.NW(NW), .DW(LDW), .QW(QW), .TW(1)) u_left_div (
        .aclk   (aclk),
        .en     (en[NS-1:3]),
        .num    (c_num_reg),
        .den    (c_ldiv_reg),
        .tag_in (c_zero_reg),
        .quo    (left_quo),
        .tag_out(d_zero)
    );

    // ---------------- saturation and sign ----------------
    logic [OUT_BITS-2:0] fwd_sat, left_mag;
    logic [OUT_BITS-1:0] left_bits;

    always_comb begin
        fwd_sat = fwd_quo[QW-1] ? LIMIT : fwd_quo[QW-2:0];
        // zero |du| gives zero even when focal_x is zero
        if (d_zero) begin
            left_mag = '0;
        end else begin
            left_mag = left_quo[QW-1] ? LIMIT : left_quo[QW-2:0];
        end
        // pixel right of center lands to the right of the robot's axis: negate
        left_bits = (!d_neg && !d_zero) ? (OUT_BITS'(0) - {1'b0, left_mag})
                                        : {1'b0, left_mag};
    end

    // ---------------- valid bits and output register ----------------
    logic [OUT_BITS-2:0]       fwd_reg;
    logic signed [OUT_BITS-1:0] left_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid && keep;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            if (en[NS]) begin
                m_valid_reg <= v_reg[NS-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NS]) begin
            fwd_reg  <= fwd_sat;
            left_reg <= left_bits;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_forward_mm = fwd_reg;
    assign m_left_mm    = left_reg;

    // ---------------- assertions ----------------
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_mm != {1'b1, {(OUT_BITS-1){1'b0}}}))
        else $error("left offset outside symmetric range");

    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NS-1] && en[NS]) |=> m_valid)
        else $error("finished item lost before output register");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v_reg[0] && m_valid))
        else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire
